[rtl/tecs_pkg.sv]
// ----------------------------------------------------------------------------
// tecs_pkg: thermoelectric climate sequencer shared definitions
// Transaction types, sequencer mode codes, request codes and register indexes.
// ----------------------------------------------------------------------------
package tecs_pkg;

    typedef enum logic [3:0] {
        MODE_OFF       = 4'd0,
        MODE_PRECOOL   = 4'd1,
        MODE_PREHEAT   = 4'd2,
        MODE_COOLING   = 4'd3,
        MODE_HEATING   = 4'd4,
        MODE_COOLDOWN  = 4'd5,
        MODE_COOLCOAST = 4'd6,
        MODE_HEATUP    = 4'd7,
        MODE_HEATCOAST = 4'd8,
        MODE_RADPUMP   = 4'd9,
        MODE_SHIRTPUMP = 4'd10
    } mode_t;

    // user request codes; 5..7 request nothing
    localparam logic [2:0] REQ_OFF       = 3'd0;
    localparam logic [2:0] REQ_COOL      = 3'd1;
    localparam logic [2:0] REQ_HEAT      = 3'd2;
    localparam logic [2:0] REQ_RADPUMP   = 3'd3;
    localparam logic [2:0] REQ_SHIRTPUMP = 3'd4;

    // configuration register indexes
    localparam logic [2:0] CFG_MIN_MODE     = 3'd0;
    localparam logic [2:0] CFG_PRE_PHASE    = 3'd1;
    localparam logic [2:0] CFG_CYCLE        = 3'd2;
    localparam logic [2:0] CFG_PUMP_CHECK   = 3'd3;
    localparam logic [2:0] CFG_FALL_BEHIND  = 3'd4;
    localparam logic [2:0] CFG_PRECOOL_TGT  = 3'd5;
    localparam logic [2:0] CFG_RADIATOR_MAX = 3'd6;
    localparam logic [2:0] CFG_SHIRT_MAX    = 3'd7;

    localparam int CFG_DATA_W = 12;

    // fixed limits, tenths of a degree / tenths of a millilitre
    localparam logic signed [12:0] MIN_TEMP_TENTHS = 13'sd10;
    localparam logic [10:0]        RAMP_TENTHS     = 11'd20;
    localparam logic [11:0]        MIN_FLOW_TENTHS = 12'd10;
    localparam logic [6:0]         FULL_POWER      = 7'd100;

    typedef struct packed {
        logic [2:0]         user_mode;
        logic [8:0]         setpoint_tenths;
        logic signed [11:0] shirt_temp_tenths;
        logic signed [11:0] radiator_temp_tenths;
        logic [11:0]        radiator_flow_tenths;
        logic [11:0]        shirt_flow_tenths;
        logic [31:0]        now_seconds;
    } sample_t;

    typedef struct packed {
        logic [3:0] system_mode;
        logic       heat_direction;
        logic [6:0] drive_percent;
        logic       radiator_pump_on;
        logic       shirt_pump_on;
        logic       fan_on;
    } result_t;

endpackage

[rtl/thermoelectric_climate_sequencer.sv]
// ----------------------------------------------------------------------------
// thermoelectric_climate_sequencer
// Eleven-state heat/cool sequencer driving thermoelectric power, pumps and fan.
// ----------------------------------------------------------------------------
// One sample transaction per one-second tick goes in; exactly one result
// transaction comes out per sample, via the sample and result registers.
// The block sustains one transaction per clock while the result side is not
// stalled: a sample register feeds the sequencer logic, whose decision is
// written into the mode/time state and the result register at the same edge,
// so the next sample can follow straight behind. The mode state loop (mode,
// mode-entry time, last-good pump times) closes at that edge and sets that
// rate. The result register separates the two sides, so a new sample is
// still taken into an empty sample register while a finished result waits.
// Configuration registers are written through a plain write port and must
// only be changed while idle. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module thermoelectric_climate_sequencer
    import tecs_pkg::*;
#(
    parameter int TIME_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_wen,
    input  logic [2:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // sample channel
    input  logic                  sample_valid,
    output logic                  sample_stall,
    input  sample_t               sample,
    // result channel
    output logic                  result_valid,
    input  logic                  result_stall,
    output result_t               result
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [7:0]  min_mode_reg;
    logic [11:0] pre_phase_reg;
    logic [7:0]  cycle_reg;
    logic [7:0]  pump_check_reg;
    logic [7:0]  fall_behind_reg;
    logic [8:0]  precool_tgt_reg;
    logic [10:0] radiator_max_reg;
    logic [10:0] shirt_max_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_mode_reg     <= 8'd20;
            pre_phase_reg    <= 12'd300;
            cycle_reg        <= 8'd30;
            pump_check_reg   <= 8'd10;
            fall_behind_reg  <= 8'd50;
            precool_tgt_reg  <= 9'd20;
            radiator_max_reg <= 11'd900;
            shirt_max_reg    <= 11'd400;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                CFG_MIN_MODE:     min_mode_reg     <= cfg_data[7:0];
                CFG_PRE_PHASE:    pre_phase_reg    <= cfg_data[11:0];
                CFG_CYCLE:        cycle_reg        <= cfg_data[7:0];
                CFG_PUMP_CHECK:   pump_check_reg   <= cfg_data[7:0];
                CFG_FALL_BEHIND:  fall_behind_reg  <= cfg_data[7:0];
                CFG_PRECOOL_TGT:  precool_tgt_reg  <= cfg_data[8:0];
                CFG_RADIATOR_MAX: radiator_max_reg <= cfg_data[10:0];
                CFG_SHIRT_MAX:    shirt_max_reg    <= cfg_data[10:0];
                default:          min_mode_reg     <= min_mode_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake: sample register -> sequencer -> result register.
    // The sample register advances whenever the result register is free
    // or being emptied this cycle.
    // ------------------------------------------------------------------
    logic    s1_valid_reg;
    sample_t s1_reg;
    logic    result_valid_reg;
    result_t result_reg;
    result_t result_next;
    logic    advance;
    logic    sample_take;

    assign advance      = s1_valid_reg && (!result_valid_reg || !result_stall);
    assign sample_stall = s1_valid_reg && !advance;
    assign sample_take  = sample_valid && !sample_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (sample_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_take)
        begin
            s1_reg <= sample;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    mode_t                mode_reg;
    mode_t                mode_next;
    logic [TIME_BITS-1:0] entered_reg;
    logic [TIME_BITS-1:0] entered_next;
    logic [TIME_BITS-1:0] rseen_reg;
    logic [TIME_BITS-1:0] rseen_next;
    logic [TIME_BITS-1:0] sseen_reg;
    logic [TIME_BITS-1:0] sseen_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_OFF;
            entered_reg <= '0;
            rseen_reg   <= '0;
            sseen_reg   <= '0;
        end
        else if (advance)
        begin
            mode_reg    <= mode_next;
            entered_reg <= entered_next;
            rseen_reg   <= rseen_next;
            sseen_reg   <= sseen_next;
        end
    end

    // ------------------------------------------------------------------
    // Sample decode and comparisons
    // ------------------------------------------------------------------
    logic [TIME_BITS-1:0] now_t;
    logic signed [12:0]   shirt_w;
    logic signed [12:0]   rad_w;
    logic signed [12:0]   set_w;
    logic signed [12:0]   set_ramp_w;
    logic signed [13:0]   err_cool;
    logic signed [13:0]   err;
    logic signed [13:0]   err_neg;
    logic                 heat_mode;
    logic                 shirt_at_target;
    logic                 shirt_warm;
    logic                 rad_ok;
    logic                 shirt_ok;

    assign now_t      = TIME_BITS'(s1_reg.now_seconds);
    assign shirt_w    = 13'(s1_reg.shirt_temp_tenths);
    assign rad_w      = 13'(s1_reg.radiator_temp_tenths);
    assign set_w      = $signed({4'b0, s1_reg.setpoint_tenths});
    assign set_ramp_w = $signed({2'b0, ({2'b0, s1_reg.setpoint_tenths} + RAMP_TENTHS)});

    assign shirt_at_target = shirt_w <= $signed({4'b0, precool_tgt_reg});
    assign shirt_warm      = shirt_w >= set_ramp_w;
    assign rad_ok   = (rad_w >= MIN_TEMP_TENTHS) && (rad_w <= $signed({2'b0, radiator_max_reg}));
    assign shirt_ok = (shirt_w >= MIN_TEMP_TENTHS) && (shirt_w <= $signed({2'b0, shirt_max_reg}));

    // shirt error: positive means the loop is behind its target
    assign heat_mode = (mode_reg == MODE_HEATING);
    assign err_cool  = 14'(shirt_w) - 14'(set_w);
    assign err       = heat_mode ? -err_cool : err_cool;
    assign err_neg   = -err;

    // elapsed times, all modulo 2^TIME_BITS
    logic [TIME_BITS-1:0] age_cur;
    assign age_cur = now_t - entered_reg;

    logic falling_behind;
    assign falling_behind = ((mode_reg == MODE_COOLING) || (mode_reg == MODE_HEATING))
                            && (age_cur > TIME_BITS'(cycle_reg))
                            && (err > $signed({6'b0, fall_behind_reg}));

    // ------------------------------------------------------------------
    // Early phase overrides (cool-down, heat-up and coasts): ahead of the
    // user transition
    // ------------------------------------------------------------------
    mode_t                mode_a;
    logic [TIME_BITS-1:0] entered_a;

    always_comb
    begin
        mode_a    = mode_reg;
        entered_a = entered_reg;
        case (mode_reg)
            MODE_COOLDOWN:
            begin
                if (shirt_at_target || (age_cur > TIME_BITS'(cycle_reg)))
                begin
                    mode_a    = MODE_COOLING;
                    entered_a = now_t;
                end
            end
            MODE_HEATUP:
            begin
                if (shirt_warm || (age_cur > TIME_BITS'(cycle_reg)))
                begin
                    mode_a    = MODE_HEATING;
                    entered_a = now_t;
                end
            end
            MODE_COOLCOAST:
            begin
                if (age_cur > TIME_BITS'(cycle_reg))
                begin
                    mode_a    = MODE_COOLDOWN;
                    entered_a = now_t;
                end
            end
            MODE_HEATCOAST:
            begin
                if (age_cur > TIME_BITS'(cycle_reg))
                begin
                    mode_a    = MODE_HEATUP;
                    entered_a = now_t;
                end
            end
            default:
            begin
                mode_a    = mode_reg;
                entered_a = entered_reg;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // User-driven transition, with pump health from this tick's flows
    // ------------------------------------------------------------------
    logic [TIME_BITS-1:0] rseen_upd;
    logic [TIME_BITS-1:0] sseen_upd;
    logic [TIME_BITS-1:0] rpump_age;
    logic [TIME_BITS-1:0] spump_age;
    logic [TIME_BITS-1:0] age_a;
    logic                 rpump_ok;
    logic                 spump_ok;
    logic                 in_dwell;
    logic                 cool_family;
    logic                 heat_family;
    mode_t                mode_b;
    logic [TIME_BITS-1:0] entered_b;

    assign rseen_upd = (s1_reg.radiator_flow_tenths >= MIN_FLOW_TENTHS) ? now_t : rseen_reg;
    assign sseen_upd = (s1_reg.shirt_flow_tenths >= MIN_FLOW_TENTHS) ? now_t : sseen_reg;
    assign rpump_age = now_t - rseen_upd;
    assign spump_age = now_t - sseen_upd;
    assign rpump_ok  = rpump_age <= TIME_BITS'(pump_check_reg);
    assign spump_ok  = spump_age <= TIME_BITS'(pump_check_reg);
    assign age_a     = now_t - entered_a;
    assign in_dwell  = age_a <= TIME_BITS'(min_mode_reg);

    assign cool_family = (mode_a == MODE_PRECOOL) || (mode_a == MODE_COOLING)
                         || (mode_a == MODE_COOLDOWN) || (mode_a == MODE_COOLCOAST);
    assign heat_family = (mode_a == MODE_PREHEAT) || (mode_a == MODE_HEATING)
                         || (mode_a == MODE_HEATUP) || (mode_a == MODE_HEATCOAST);

    always_comb
    begin
        mode_b = mode_a;
        case (s1_reg.user_mode)
            REQ_OFF:
            begin
                mode_b = MODE_OFF;
            end
            REQ_COOL:
            begin
                if (in_dwell)
                begin
                    mode_b = mode_a;
                end
                else if (!(rad_ok && shirt_ok))
                begin
                    mode_b = MODE_OFF;
                end
                else if (!cool_family)
                begin
                    mode_b = MODE_PRECOOL;
                end
                else if ((mode_a == MODE_COOLING) && (!rpump_ok || !spump_ok))
                begin
                    mode_b = MODE_COOLCOAST;
                end
            end
            REQ_HEAT:
            begin
                if (in_dwell)
                begin
                    mode_b = mode_a;
                end
                else if (!(rad_ok && shirt_ok))
                begin
                    mode_b = MODE_OFF;
                end
                else if (!heat_family)
                begin
                    mode_b = MODE_PREHEAT;
                end
                else if ((mode_a == MODE_HEATING) && (!rpump_ok || !spump_ok))
                begin
                    mode_b = MODE_HEATCOAST;
                end
            end
            REQ_RADPUMP:
            begin
                if (in_dwell)
                begin
                    mode_b = mode_a;
                end
                else if (!rad_ok || ((mode_a == MODE_RADPUMP) && !rpump_ok))
                begin
                    mode_b = MODE_OFF;
                end
                else
                begin
                    mode_b = MODE_RADPUMP;
                end
            end
            REQ_SHIRTPUMP:
            begin
                if (in_dwell)
                begin
                    mode_b = mode_a;
                end
                else if (!shirt_ok || ((mode_a == MODE_SHIRTPUMP) && !spump_ok))
                begin
                    mode_b = MODE_OFF;
                end
                else
                begin
                    mode_b = MODE_SHIRTPUMP;
                end
            end
            default:
            begin
                mode_b = mode_a;
            end
        endcase
    end

    assign entered_b = (mode_b != mode_a) ? now_t : entered_a;

    // ------------------------------------------------------------------
    // Late overrides for precool/preheat: after the user transition, and
    // they win even over an off request
    // ------------------------------------------------------------------
    logic [TIME_BITS-1:0] age_b;
    logic                 pre_timeout;
    mode_t                mode_c;
    logic [TIME_BITS-1:0] entered_c;

    assign age_b       = now_t - entered_b;
    assign pre_timeout = age_b > TIME_BITS'(pre_phase_reg);

    always_comb
    begin
        mode_c    = mode_b;
        entered_c = entered_b;
        case (mode_reg)
            MODE_PRECOOL:
            begin
                if (shirt_at_target || pre_timeout)
                begin
                    mode_c    = MODE_COOLING;
                    entered_c = now_t;
                end
            end
            MODE_PREHEAT:
            begin
                if (shirt_warm || pre_timeout)
                begin
                    mode_c    = MODE_HEATING;
                    entered_c = now_t;
                end
            end
            default:
            begin
                mode_c    = mode_b;
                entered_c = entered_b;
            end
        endcase
    end

    // falling behind skips the user transition, flows of the tick are ignored
    always_comb
    begin
        if (falling_behind)
        begin
            mode_next    = heat_mode ? MODE_HEATUP : MODE_COOLDOWN;
            entered_next = now_t;
            rseen_next   = rseen_reg;
            sseen_next   = sseen_reg;
        end
        else
        begin
            mode_next    = mode_c;
            entered_next = entered_c;
            rseen_next   = rseen_upd;
            sseen_next   = sseen_upd;
        end
    end

    // ------------------------------------------------------------------
    // Drive outputs follow the mode held at the start of the tick
    // ------------------------------------------------------------------
    logic [6:0] ramp_power;
    logic       fan_sep;

    // 5 % per tenth ahead of the setpoint, zero beyond the 2.0 C ramp
    always_comb
    begin
        if (err > 14'sd0)
        begin
            ramp_power = FULL_POWER;
        end
        else if (err_neg <= $signed({3'b0, RAMP_TENTHS}))
        begin
            ramp_power = 7'({err_neg[4:0], 2'b00} + {2'b00, err_neg[4:0]});
        end
        else
        begin
            ramp_power = 7'd0;
        end
    end

    always_comb
    begin
        result_next                  = '0;
        fan_sep                      = 1'b0;
        result_next.system_mode      = mode_next;
        case (mode_reg)
            MODE_PRECOOL, MODE_COOLDOWN:
            begin
                result_next.radiator_pump_on = 1'b1;
                result_next.drive_percent    = FULL_POWER;
            end
            MODE_PREHEAT, MODE_HEATUP:
            begin
                result_next.radiator_pump_on = 1'b1;
                result_next.heat_direction   = 1'b1;
                result_next.drive_percent    = FULL_POWER;
            end
            MODE_COOLING, MODE_HEATING:
            begin
                result_next.radiator_pump_on = 1'b1;
                result_next.heat_direction   = heat_mode;
                result_next.shirt_pump_on    = !falling_behind;
                result_next.drive_percent    = falling_behind ? FULL_POWER : ramp_power;
            end
            MODE_COOLCOAST:
            begin
                fan_sep = 1'b1;
            end
            MODE_HEATCOAST:
            begin
                result_next.radiator_pump_on = 1'b1;
                result_next.heat_direction   = 1'b1;
                fan_sep                      = 1'b1;
            end
            MODE_RADPUMP:
            begin
                result_next.radiator_pump_on = 1'b1;
            end
            MODE_SHIRTPUMP:
            begin
                result_next.shirt_pump_on = 1'b1;
            end
            default:
            begin
                fan_sep = 1'b0;
            end
        endcase
        result_next.fan_on = result_next.radiator_pump_on || fan_sep;
    end

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
`ifndef SYNTH
    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(mode_reg) && $stable(entered_reg))
        else $error("sequencer state changed without a transaction");

    a_entry_time: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (mode_next != mode_reg) |=> entered_reg == $past(now_t))
        else $error("mode change did not record entry time");

    a_result_mode: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> result_reg.system_mode == mode_reg)
        else $error("result mode differs from sequencer state");

    a_stall_occupied: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> s1_valid_reg && result_valid_reg && result_stall)
        else $error("sample stalled with room in the pipeline");
`endif

endmodule

[test/sequencer_checker.sv]
// ----------------------------------------------------------------------------
// sequencer_checker: prediction and comparison for the climate sequencer
// Follows register writes and accepted sample transactions, works out the
// result each sample should give and compares it with what the block returns.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sequencer_checker
    import tecs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wen,
    input  logic [2:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  sample_valid,
    input  logic                  sample_stall,
    input  sample_t               sample,
    input  logic                  result_valid,
    input  logic                  result_stall,
    input  result_t               result,
    output int                    fail_count,
    output int                    pending,
    output int                    checked,
    output logic [15:0]           modes_seen
);

    // register values after reset
    localparam logic [7:0]  RST_MIN_MODE   = 8'd20;
    localparam logic [11:0] RST_PRE_PHASE  = 12'd300;
    localparam logic [7:0]  RST_CYCLE      = 8'd30;
    localparam logic [7:0]  RST_PUMP_CHECK = 8'd10;
    localparam logic [7:0]  RST_FALL       = 8'd50;
    localparam logic [8:0]  RST_TARGET     = 9'd20;
    localparam logic [10:0] RST_RAD_MAX    = 11'd900;
    localparam logic [10:0] RST_SHIRT_MAX  = 11'd400;

    logic [7:0]  min_mode_s;
    logic [11:0] pre_phase_s;
    logic [7:0]  cycle_s;
    logic [7:0]  pump_check_s;
    logic [7:0]  fall_behind;
    logic [8:0]  precool_tgt;
    logic [10:0] rad_max;
    logic [10:0] shirt_max;

    mode_t       seq_mode;
    logic [31:0] entered_at;
    logic [31:0] rad_flow_at;
    logic [31:0] shirt_flow_at;

    result_t     predicted_outputs[$];
    int          mismatches;
    int          compared;
    logic [15:0] visited;

    // user-driven transition; also refreshes the pump health stamps
    function automatic mode_t request_step(input mode_t cur, input sample_t s);
        mode_t       nxt;
        logic [31:0] now;
        int          shirt;
        int          rad;
        logic        rad_ok;
        logic        shirt_ok;
        logic        rpump_ok;
        logic        spump_ok;
        nxt   = cur;
        now   = s.now_seconds;
        shirt = $signed(s.shirt_temp_tenths);
        rad   = $signed(s.radiator_temp_tenths);
        if (s.radiator_flow_tenths >= MIN_FLOW_TENTHS)
            rad_flow_at = now;
        if (s.shirt_flow_tenths >= MIN_FLOW_TENTHS)
            shirt_flow_at = now;
        rad_ok   = rad >= int'(MIN_TEMP_TENTHS) && rad <= int'(rad_max);
        shirt_ok = shirt >= int'(MIN_TEMP_TENTHS) && shirt <= int'(shirt_max);
        rpump_ok = (now - rad_flow_at) <= pump_check_s;
        spump_ok = (now - shirt_flow_at) <= pump_check_s;

        if (s.user_mode == REQ_OFF)
        begin
            nxt = MODE_OFF;
        end
        else if (s.user_mode <= REQ_SHIRTPUMP)
        begin
            if ((now - entered_at) <= min_mode_s)
                return cur;
            case (s.user_mode)
                REQ_COOL:
                begin
                    if (rad_ok && shirt_ok)
                    begin
                        if (cur != MODE_PRECOOL && cur != MODE_COOLING &&
                            cur != MODE_COOLDOWN && cur != MODE_COOLCOAST)
                            nxt = MODE_PRECOOL;
                        if (nxt == MODE_COOLING && (!rpump_ok || !spump_ok))
                            nxt = MODE_COOLCOAST;
                    end
                    else
                        nxt = MODE_OFF;
                end
                REQ_HEAT:
                begin
                    if (rad_ok && shirt_ok)
                    begin
                        if (cur != MODE_PREHEAT && cur != MODE_HEATING &&
                            cur != MODE_HEATUP && cur != MODE_HEATCOAST)
                            nxt = MODE_PREHEAT;
                        if (nxt == MODE_HEATING && (!rpump_ok || !spump_ok))
                            nxt = MODE_HEATCOAST;
                    end
                    else
                        nxt = MODE_OFF;
                end
                REQ_RADPUMP:
                begin
                    if (rad_ok)
                    begin
                        nxt = MODE_RADPUMP;
                        if (cur == MODE_RADPUMP && !rpump_ok)
                            nxt = MODE_OFF;
                    end
                    else
                        nxt = MODE_OFF;
                end
                default:
                begin
                    if (shirt_ok)
                    begin
                        nxt = MODE_SHIRTPUMP;
                        if (cur == MODE_SHIRTPUMP && !spump_ok)
                            nxt = MODE_OFF;
                    end
                    else
                        nxt = MODE_OFF;
                end
            endcase
        end
        else
        begin
            return cur;
        end
        if (nxt != cur)
            entered_at = now;
        return nxt;
    endfunction

    // one tick of the sequencer: outputs follow the mode held at entry
    function automatic result_t advance_sequencer(input sample_t s);
        result_t     r;
        mode_t       m;
        logic [31:0] now;
        int          set;
        int          shirt;
        int          err;
        int          tgt;
        int          fb;
        int          ramp;
        logic        heat;
        logic        rp;
        logic        sp;
        logic        coast_fan;
        logic [6:0]  pwr;
        m         = seq_mode;
        now       = s.now_seconds;
        set       = int'(s.setpoint_tenths);
        shirt     = $signed(s.shirt_temp_tenths);
        tgt       = int'(precool_tgt);
        fb        = int'(fall_behind);
        ramp      = int'(RAMP_TENTHS);
        heat      = 1'b0;
        rp        = 1'b0;
        sp        = 1'b0;
        coast_fan = 1'b0;
        pwr       = 7'd0;

        case (seq_mode)
            MODE_PRECOOL:
            begin
                rp  = 1'b1;
                pwr = FULL_POWER;
                m   = request_step(m, s);
                if (shirt <= tgt)
                begin
                    m = MODE_COOLING;
                    entered_at = now;
                end
                if ((now - entered_at) > pre_phase_s)
                begin
                    m = MODE_COOLING;
                    entered_at = now;
                end
            end
            MODE_PREHEAT:
            begin
                rp   = 1'b1;
                heat = 1'b1;
                pwr  = FULL_POWER;
                m    = request_step(m, s);
                if (shirt >= set + ramp)
                begin
                    m = MODE_HEATING;
                    entered_at = now;
                end
                if ((now - entered_at) > pre_phase_s)
                begin
                    m = MODE_HEATING;
                    entered_at = now;
                end
            end
            MODE_COOLING, MODE_HEATING:
            begin
                rp   = 1'b1;
                sp   = 1'b1;
                heat = (seq_mode == MODE_HEATING);
                err  = heat ? (set - shirt) : (shirt - set);
                if ((now - entered_at) > cycle_s && err > fb)
                begin
                    // falling behind: flows and request are not looked at
                    sp  = 1'b0;
                    pwr = FULL_POWER;
                    m   = heat ? MODE_HEATUP : MODE_COOLDOWN;
                    entered_at = now;
                end
                else
                begin
                    if (err > 0)
                        pwr = FULL_POWER;
                    else if (-err <= ramp)
                        pwr = 7'(5 * (-err));
                    else
                        pwr = 7'd0;
                    m = request_step(m, s);
                end
            end
            MODE_COOLDOWN:
            begin
                rp  = 1'b1;
                pwr = FULL_POWER;
                if (shirt <= tgt)
                begin
                    m = MODE_COOLING;
                    entered_at = now;
                end
                if ((now - entered_at) > cycle_s)
                begin
                    m = MODE_COOLING;
                    entered_at = now;
                end
                m = request_step(m, s);
            end
            MODE_COOLCOAST:
            begin
                coast_fan = 1'b1;
                if ((now - entered_at) > cycle_s)
                begin
                    m = MODE_COOLDOWN;
                    entered_at = now;
                end
                m = request_step(m, s);
            end
            MODE_HEATUP:
            begin
                rp   = 1'b1;
                heat = 1'b1;
                pwr  = FULL_POWER;
                if (shirt >= set + ramp)
                begin
                    m = MODE_HEATING;
                    entered_at = now;
                end
                if ((now - entered_at) > cycle_s)
                begin
                    m = MODE_HEATING;
                    entered_at = now;
                end
                m = request_step(m, s);
            end
            MODE_HEATCOAST:
            begin
                rp        = 1'b1;
                heat      = 1'b1;
                coast_fan = 1'b1;
                if ((now - entered_at) > cycle_s)
                begin
                    m = MODE_HEATUP;
                    entered_at = now;
                end
                m = request_step(m, s);
            end
            MODE_RADPUMP:
            begin
                rp = 1'b1;
                m  = request_step(m, s);
            end
            MODE_SHIRTPUMP:
            begin
                sp = 1'b1;
                m  = request_step(m, s);
            end
            default:
                m = request_step(m, s);
        endcase

        seq_mode           = m;
        r.system_mode      = m;
        r.heat_direction   = heat;
        r.drive_percent    = pwr;
        r.radiator_pump_on = rp;
        r.shirt_pump_on    = sp;
        r.fan_on           = rp | coast_fan;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            min_mode_s    = RST_MIN_MODE;
            pre_phase_s   = RST_PRE_PHASE;
            cycle_s       = RST_CYCLE;
            pump_check_s  = RST_PUMP_CHECK;
            fall_behind   = RST_FALL;
            precool_tgt   = RST_TARGET;
            rad_max       = RST_RAD_MAX;
            shirt_max     = RST_SHIRT_MAX;
            seq_mode      = MODE_OFF;
            entered_at    = '0;
            rad_flow_at   = '0;
            shirt_flow_at = '0;
            predicted_outputs.delete();
            mismatches    = 0;
            compared      = 0;
            visited       = '0;
        end
        else
        begin
            if (cfg_wen)
            begin
                case (cfg_index)
                    CFG_MIN_MODE:     min_mode_s   = cfg_data[7:0];
                    CFG_PRE_PHASE:    pre_phase_s  = cfg_data[11:0];
                    CFG_CYCLE:        cycle_s      = cfg_data[7:0];
                    CFG_PUMP_CHECK:   pump_check_s = cfg_data[7:0];
                    CFG_FALL_BEHIND:  fall_behind  = cfg_data[7:0];
                    CFG_PRECOOL_TGT:  precool_tgt  = cfg_data[8:0];
                    CFG_RADIATOR_MAX: rad_max      = cfg_data[10:0];
                    CFG_SHIRT_MAX:    shirt_max    = cfg_data[10:0];
                    default:          ;
                endcase
            end

            if (sample_valid && !sample_stall)
                predicted_outputs.push_back(advance_sequencer(sample));

            if (result_valid && !result_stall)
            begin
                compared++;
                if (predicted_outputs.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result transaction with none outstanding: mode=%0d",
                                 $realtime, result.system_mode);
                end
                else
                begin
                    want = predicted_outputs.pop_front();
                    visited[want.system_mode] = 1'b1;
                    if (result.system_mode      !== want.system_mode      ||
                        result.heat_direction   !== want.heat_direction   ||
                        result.drive_percent    !== want.drive_percent    ||
                        result.radiator_pump_on !== want.radiator_pump_on ||
                        result.shirt_pump_on    !== want.shirt_pump_on    ||
                        result.fan_on           !== want.fan_on)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: result %0d mismatch, exp mode=%0d dir=%0d pwr=%0d",
                                     $realtime, compared, want.system_mode,
                                     want.heat_direction, want.drive_percent,
                                     " rp=%0d sp=%0d fan=%0d, got mode=%0d dir=%0d pwr=%0d",
                                     want.radiator_pump_on, want.shirt_pump_on, want.fan_on,
                                     result.system_mode, result.heat_direction,
                                     result.drive_percent,
                                     " rp=%0d sp=%0d fan=%0d",
                                     result.radiator_pump_on, result.shirt_pump_on,
                                     result.fan_on);
                    end
                end
            end
        end
        fail_count <= mismatches;
        pending    <= predicted_outputs.size();
        checked    <= compared;
        modes_seen <= visited;
    end

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: thermoelectric climate sequencer
// Drives sample transactions through a directed opening and several
// randomised phases under different register settings, with random idling on
// both channels; the checker alongside predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench
    import tecs_pkg::*;
();

    // generous bound for the whole run
    localparam int CYCLE_LIMIT = 400000;
    localparam int LAST_PHASE  = 6;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wen;
    logic [2:0]            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  sample_valid;
    logic                  sample_stall;
    sample_t               sample;
    logic                  result_valid;
    logic                  result_stall;
    result_t               result;

    int                    fail_count;
    int                    pending;
    int                    checked;
    logic [15:0]           modes_seen;

    int                    cycle_count = 0;
    bit                    idling_on;
    int                    sent;
    int                    settings_used;
    int                    phase_len;
    logic [CFG_DATA_W-1:0] cfg_next [8];

    // stimulus scenario: a seconds clock, a held request and drifting loops
    logic [31:0]           stim_now;
    logic [2:0]            held_req;
    logic [8:0]            held_set;
    int                    hold_ticks;
    int                    shirt_now;
    int                    rad_now;
    int                    rad_dry;
    int                    shirt_dry;

    thermoelectric_climate_sequencer uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wen      (cfg_wen),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    sequencer_checker seq_check
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wen      (cfg_wen),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .fail_count   (fail_count),
        .pending      (pending),
        .checked      (checked),
        .modes_seen   (modes_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // watchdog: a hang anywhere ends the run as a failure
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side back-pressure: random stall bursts while idling
    // is enabled, none in the final phase
    initial
    begin
        int stall_left;
        stall_left   = 0;
        result_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
                stall_left--;
            else if (idling_on && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 4);
            result_stall <= (stall_left > 0);
        end
    end

    function automatic sample_t mk(input logic [2:0] req, input int set, input int shirt,
                                   input int rad, input int rflow, input int sflow,
                                   input logic [31:0] now);
        sample_t s;
        s.user_mode            = req;
        s.setpoint_tenths      = 9'(set);
        s.shirt_temp_tenths    = 12'(shirt);
        s.radiator_temp_tenths = 12'(rad);
        s.radiator_flow_tenths = 12'(rflow);
        s.shirt_flow_tenths    = 12'(sflow);
        s.now_seconds          = now;
        return s;
    endfunction

    // flow volume for one tick: a trickle below the health threshold while the
    // pump is "dry", otherwise anything from exactly the threshold upwards
    function automatic logic [11:0] flow_amount(input bit dry);
        if (dry)
            return 12'($urandom_range(0, MIN_FLOW_TENTHS - 1));
        if ($urandom_range(0, 7) == 0)
            return MIN_FLOW_TENTHS;
        return 12'($urandom_range(MIN_FLOW_TENTHS, 4095));
    endfunction

    // next tick of the scenario; mostly plausible, with a little noise so
    // that every field bit and the unused request codes are exercised
    function automatic sample_t next_tick();
        sample_t s;
        int      roll;

        roll = $urandom_range(0, 99);
        if (roll < 85)
            stim_now = stim_now + 1;
        else if (roll < 94)
            stim_now = stim_now + $urandom_range(2, 90);
        else if (roll >= 99)
            stim_now = $urandom();
        else if (roll >= 97)
            stim_now = 32'hFFFF_FFC0 + $urandom_range(0, 63);   // run up to the wrap
        // otherwise the same second repeats

        if (hold_ticks <= 0)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 30)
                held_req = REQ_COOL;
            else if (roll < 60)
                held_req = REQ_HEAT;
            else if (roll < 72)
                held_req = REQ_OFF;
            else if (roll < 82)
                held_req = REQ_RADPUMP;
            else if (roll < 92)
                held_req = REQ_SHIRTPUMP;
            else
                held_req = 3'($urandom_range(REQ_SHIRTPUMP + 1, 7));
            hold_ticks = $urandom_range(3, 60);
            held_set = ($urandom_range(0, 19) == 0) ? 9'($urandom())
                                                    : 9'($urandom_range(10, 320));
        end
        hold_ticks--;

        // shirt: slow drift, with jumps around the setpoint (falling behind,
        // preheat exit, ramp) and down near the precool target
        roll = $urandom_range(0, 99);
        if (roll < 8)
            shirt_now = int'(held_set) + int'($urandom_range(0, 200)) - 100;
        else if (roll < 12)
            shirt_now = int'($urandom_range(0, 60)) - 20;
        else
            shirt_now = shirt_now + int'($urandom_range(0, 12)) - 6;
        if (shirt_now < -400)
            shirt_now = -400;
        if (shirt_now > 1500)
            shirt_now = 1500;

        roll = $urandom_range(0, 99);
        if (roll < 5)
            rad_now = int'($urandom_range(0, 1900)) - 400;
        else if (roll < 10)
            rad_now = int'($urandom_range(100, 800));
        else
            rad_now = rad_now + int'($urandom_range(0, 20)) - 10;
        if (rad_now < -400)
            rad_now = -400;
        if (rad_now > 1500)
            rad_now = 1500;

        if (rad_dry == 0 && $urandom_range(0, 39) == 0)
            rad_dry = $urandom_range(1, 30);
        if (shirt_dry == 0 && $urandom_range(0, 39) == 0)
            shirt_dry = $urandom_range(1, 30);

        s.user_mode            = ($urandom_range(0, 29) == 0) ? 3'($urandom()) : held_req;
        s.setpoint_tenths      = held_set;
        s.shirt_temp_tenths    = ($urandom_range(0, 39) == 0) ? 12'($urandom())
                                                              : 12'(shirt_now);
        s.radiator_temp_tenths = ($urandom_range(0, 39) == 0) ? 12'($urandom())
                                                              : 12'(rad_now);
        s.radiator_flow_tenths = flow_amount(rad_dry > 0);
        s.shirt_flow_tenths    = flow_amount(shirt_dry > 0);
        s.now_seconds          = stim_now;
        if (rad_dry > 0)
            rad_dry--;
        if (shirt_dry > 0)
            shirt_dry--;
        return s;
    endfunction

    // offer one sample transaction, optionally after an idle burst, and hold
    // it until the block takes it
    task automatic push_sample(input sample_t s);
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= s;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        sent++;
    endtask

    // let every outstanding result come back, then wait on so that any stray
    // extra transaction would still be seen
    task automatic drain();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // all eight registers, back to back; only called while the block is idle
    task automatic write_settings();
        for (int i = 0; i < 8; i++)
        begin
            cfg_wen   <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data  <= cfg_next[i];
            @(posedge clk);
        end
        cfg_wen <= 1'b0;
        settings_used++;
    endtask

    task automatic pick_settings(input int phase);
        case (phase)
            0:
            begin
                // reset values, written explicitly
                cfg_next[CFG_MIN_MODE]     = 12'd20;
                cfg_next[CFG_PRE_PHASE]    = 12'd300;
                cfg_next[CFG_CYCLE]        = 12'd30;
                cfg_next[CFG_PUMP_CHECK]   = 12'd10;
                cfg_next[CFG_FALL_BEHIND]  = 12'd50;
                cfg_next[CFG_PRECOOL_TGT]  = 12'd20;
                cfg_next[CFG_RADIATOR_MAX] = 12'd900;
                cfg_next[CFG_SHIRT_MAX]    = 12'd400;
                phase_len = 250;
            end
            1:
            begin
                // zero timings and thresholds, widest temperature windows
                cfg_next[CFG_MIN_MODE]     = 12'd0;
                cfg_next[CFG_PRE_PHASE]    = 12'd0;
                cfg_next[CFG_CYCLE]        = 12'd0;
                cfg_next[CFG_PUMP_CHECK]   = 12'd0;
                cfg_next[CFG_FALL_BEHIND]  = 12'd0;
                cfg_next[CFG_PRECOOL_TGT]  = 12'd0;
                cfg_next[CFG_RADIATOR_MAX] = 12'd1500;
                cfg_next[CFG_SHIRT_MAX]    = 12'd1500;
                phase_len = 250;
            end
            2:
            begin
                // timing and falling-behind registers at their top values, high limits
                cfg_next[CFG_MIN_MODE]     = 12'd255;
                cfg_next[CFG_PRE_PHASE]    = 12'd4095;
                cfg_next[CFG_CYCLE]        = 12'd255;
                cfg_next[CFG_PUMP_CHECK]   = 12'd255;
                cfg_next[CFG_FALL_BEHIND]  = 12'd255;
                cfg_next[CFG_PRECOOL_TGT]  = 12'd400;
                cfg_next[CFG_RADIATOR_MAX] = 12'd1500;
                cfg_next[CFG_SHIRT_MAX]    = 12'd1500;
                phase_len = 150;
            end
            3:
            begin
                // all zero: no temperature is ever in range
                for (int i = 0; i < 8; i++)
                    cfg_next[i] = '0;
                phase_len = 50;
            end
            default:
            begin
                // short dwells so the sequencer travels a long way per phase
                cfg_next[CFG_MIN_MODE]     = 12'($urandom_range(0, 8));
                cfg_next[CFG_PRE_PHASE]    = 12'($urandom_range(0, 40));
                cfg_next[CFG_CYCLE]        = 12'($urandom_range(0, 20));
                cfg_next[CFG_PUMP_CHECK]   = 12'($urandom_range(0, 8));
                cfg_next[CFG_FALL_BEHIND]  = 12'($urandom_range(0, 80));
                cfg_next[CFG_PRECOOL_TGT]  = 12'($urandom_range(0, 400));
                cfg_next[CFG_RADIATOR_MAX] = 12'($urandom_range(200, 1500));
                cfg_next[CFG_SHIRT_MAX]    = 12'($urandom_range(200, 1500));
                phase_len = 300;
            end
        endcase
    endtask

    // Directed opening under reset settings (dwell 20 s, cycle 30 s, pump
    // check 10 s, falling-behind 5.0 C, target 2.0 C). Walks the sequencer
    // through most of its modes; the checker works out every result.
    task automatic run_directed();
        // field extremes while off, then the requests that ask for nothing
        push_sample(mk(REQ_OFF, 0, -2048, 2047, 0, 0, 32'd0));
        push_sample(mk(3'd7, 511, 2047, -2048, 4095, 4095, 32'hFFFF_FFFF));
        push_sample(mk(3'd5, 320, 250, 300, 100, 100, 32'd5));
        // cool inside the dwell is ignored, after it gives precool
        push_sample(mk(REQ_COOL, 200, 250, 300, 100, 100, 32'd10));
        push_sample(mk(REQ_COOL, 200, 250, 300, 100, 100, 32'd30));
        // off request in precool is overridden by the shirt reaching target
        push_sample(mk(REQ_OFF, 200, 20, 300, 100, 100, 32'd31));
        // cooling power ramp: on setpoint, 1.0 C under, 2.0 C under, past it, over
        push_sample(mk(REQ_COOL, 200, 200, 300, 100, 100, 32'd32));
        push_sample(mk(REQ_COOL, 200, 190, 300, 100, 100, 32'd33));
        push_sample(mk(REQ_COOL, 200, 180, 300, 100, 100, 32'd34));
        push_sample(mk(REQ_COOL, 200, 179, 300, 100, 100, 32'd35));
        push_sample(mk(REQ_COOL, 200, 201, 300, 100, 100, 32'd36));
        // falling behind into cooldown, then its timeout back to cooling
        push_sample(mk(REQ_COOL, 200, 260, 300, 0, 0, 32'd100));
        push_sample(mk(REQ_COOL, 200, 240, 300, 100, 100, 32'd140));
        // pumps gone quiet: cooling falls back to coast, coast times out
        push_sample(mk(REQ_COOL, 200, 200, 300, 0, 0, 32'd170));
        push_sample(mk(REQ_COOL, 200, 200, 300, 100, 100, 32'd201));
        // heat request: preheat, shirt 2.0 C over setpoint ends it
        push_sample(mk(REQ_HEAT, 150, 200, 300, 100, 100, 32'd230));
        push_sample(mk(REQ_HEAT, 150, 175, 300, 100, 100, 32'd231));
        push_sample(mk(REQ_HEAT, 150, 160, 300, 100, 100, 32'd232));
        // heating falls behind, heat-up times out, heat coast on lost flow
        push_sample(mk(REQ_HEAT, 150, 80, 300, 100, 100, 32'd300));
        push_sample(mk(REQ_HEAT, 150, 150, 300, 0, 0, 32'd340));
        push_sample(mk(REQ_HEAT, 150, 150, 300, 0, 0, 32'd370));
        push_sample(mk(REQ_HEAT, 150, 150, 300, 100, 100, 32'd401));
        // pump modes, pump loss to off, and out-of-window temperatures
        push_sample(mk(REQ_RADPUMP, 150, 150, 300, 100, 100, 32'd430));
        push_sample(mk(REQ_RADPUMP, 150, 150, 300, 0, 0, 32'd460));
        push_sample(mk(REQ_SHIRTPUMP, 150, 150, 300, 100, 100, 32'd490));
        push_sample(mk(REQ_COOL, 150, 150, 950, 100, 100, 32'd520));
        push_sample(mk(REQ_HEAT, 150, 5, 300, 100, 100, 32'd550));
        stim_now = 32'd550;
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_wen      = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        sample_valid = 1'b0;
        sample       = '0;
        idling_on    = 1'b1;
        sent         = 0;
        settings_used = 0;
        stim_now     = '0;
        held_req     = REQ_OFF;
        held_set     = 9'd200;
        hold_ticks   = 0;
        shirt_now    = 250;
        rad_now      = 300;
        rad_dry      = 0;
        shirt_dry    = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        drain();

        // random phases; registers change only once the block has drained
        for (int phase = 0; phase <= LAST_PHASE; phase++)
        begin
            pick_settings(phase);
            write_settings();
            if (phase == LAST_PHASE)
                idling_on = 1'b0;
            repeat (phase_len) push_sample(next_tick());
            drain();
        end

        $display("Sent %0d sample transactions over %0d register settings, %0d results checked.",
                 sent, settings_used, checked);
        $display("Sequencer modes reached: %0d of 11.", $countones(modes_seen));
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[filelist.f]
rtl/tecs_pkg.sv
rtl/thermoelectric_climate_sequencer.sv
test/sequencer_checker.sv
test/testbench.sv
